### rtl/core/sdr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_pkg: shared constants and tables for the six-point design row
// Fixed-point format constants, element codes and the coefficient pair table.
// ----------------------------------------------------------------------------
package sdr_pkg;

    // Fraction bits of the signed input format.
    localparam int IN_FRAC = 16;

    // Element index codes.
    localparam logic [4:0] IDX_MATRIX_END = 5'd24;
    localparam logic [4:0] IDX_POINT_U    = 5'd24;
    localparam logic [4:0] IDX_POINT_V    = 5'd25;

    localparam logic [2:0] COEF_LAST = 3'd4;

    // Row index r of each coefficient pair (r, s).
    function automatic logic [1:0] pair_r(input logic [2:0] k);
        logic [1:0] r;
        case (k)
            3'd0:    r = 2'd0;
            3'd1:    r = 2'd0;
            3'd2:    r = 2'd1;
            3'd3:    r = 2'd1;
            3'd4:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    // Column index s of each coefficient pair (r, s).
    function automatic logic [1:0] pair_s(input logic [2:0] k);
        logic [1:0] s;
        case (k)
            3'd0:    s = 2'd1;
            3'd1:    s = 2'd2;
            3'd2:    s = 2'd2;
            3'd3:    s = 2'd3;
            3'd4:    s = 2'd3;
            default: s = 2'd1;
        endcase
        return s;
    endfunction

endpackage

### rtl/core/six_point_design_row.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_point_design_row: one row of the six-point design matrix
// Loads two 3x4 camera matrices and an image point, translates the point to
// the origin, normalises and emits the five symmetric bilinear coefficients.
// ----------------------------------------------------------------------------
//  Channel   Handshake                  Payload
//  input     start && !busy             element_index, element_value
//  result    result_valid (one cycle)   coefficient_index, coefficient_value,
//                                       degenerate, last
//
//  A load item leaves the block ready for the next item. The v item runs
//  the translate, shift-search and square steps and then, per coefficient,
//  a numerator step and a divide step (cut short when the ratio saturates
//  or the row is degenerate); these steps share one multiplier and a
//  bit-serial divider. busy is high throughout. Reset clears control state
//  only. Results cannot be stalled; each is shown for a single cycle.
// ----------------------------------------------------------------------------
module six_point_design_row
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [4:0]         element_index,
    input  logic signed [31:0] element_value,
    output logic               result_valid,
    output logic [2:0]         coefficient_index,
    output logic signed [31:0] coefficient_value,
    output logic               degenerate,
    output logic               last
);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_TRANS,
        S_SHIFT,
        S_SQUARE,
        S_NUMER,
        S_DIVIDE
    } state_t;

    state_t             state_reg;
    logic [4:0]         cnt_reg;
    logic [2:0]         k_reg;
    logic signed [31:0] u_reg;
    logic signed [31:0] v_reg;
    logic signed [31:0] top_d_reg;
    logic signed [31:0] rd_top_reg;
    logic signed [31:0] rd_bot_reg;
    logic signed [31:0] matrix_mem [24];
    logic [63:0]        t_mag_reg [16];
    logic               t_neg_reg [16];
    logic [63:0]        allmag_reg;
    logic [63:0]        sh_reg;
    logic [5:0]         shift_reg;
    logic [63:0]        den_reg;
    logic signed [29:0] x_mem [16];
    logic signed [29:0] rd_a_reg;
    logic signed [29:0] rd_b_reg;
    logic signed [63:0] num_reg;
    logic               div_wait_reg;
    logic               div_start_reg;
    logic               result_valid_reg;
    logic [2:0]         coef_index_reg;
    logic signed [31:0] coef_value_reg;
    logic               degenerate_reg;
    logic               last_reg;

    logic               accept;
    logic [3:0]         e0;
    logic [3:0]         e1;
    logic [3:0]         e2;
    logic [4:0]         top_addr;
    logic [4:0]         bot_addr;
    logic signed [64:0] top_ext;
    logic signed [64:0] tv;
    logic [63:0]        tmag;
    logic [63:0]        shifted;
    logic [28:0]        xm;
    logic signed [29:0] x_val;
    logic [1:0]         pr;
    logic [1:0]         ps;
    logic [3:0]         a_addr;
    logic [3:0]         b_addr;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;
    logic [63:0]        div_n;
    logic               div_done;
    logic               div_sat;
    logic [31:0]        div_q;
    logic signed [31:0] coef_sat;
    logic               is_degenerate;

    assign busy   = state_reg != S_IDLE;
    assign accept = start && !busy;

    assign e0 = cnt_reg[3:0];
    assign e1 = cnt_reg[3:0] - 4'd1;
    assign e2 = cnt_reg[3:0] - 4'd2;

    // Element e covers row (e / 4) and column (e % 4) of the translated set:
    // rows are A0, A1, B0, B1.
    assign top_addr = (e0[3] ? 5'd12 : 5'd0) + (e0[2] ? 5'd4 : 5'd0) + {3'b000, e0[1:0]};
    assign bot_addr = (e0[3] ? 5'd20 : 5'd8) + {3'b000, e0[1:0]};

    assign top_ext = 65'(top_d_reg);
    assign tv      = (top_ext <<< sdr_pkg::IN_FRAC) - 65'(prod);
    assign tmag    = tv[64] ? 64'(-tv) : tv[63:0];

    assign shifted = t_mag_reg[e0] >> shift_reg;
    assign xm      = shifted[28:0];
    assign x_val   = t_neg_reg[e0] ? -$signed({1'b0, xm}) : $signed({1'b0, xm});

    // Numerator terms: +A0[r]B1[s], -A1[r]B0[s], +A0[s]B1[r], -A1[s]B0[r].
    assign pr     = sdr_pkg::pair_r(k_reg);
    assign ps     = sdr_pkg::pair_s(k_reg);
    assign a_addr = {1'b0, cnt_reg[0], cnt_reg[1] ? ps : pr};
    assign b_addr = {1'b1, !cnt_reg[0], cnt_reg[1] ? pr : ps};

    assign is_degenerate = allmag_reg == 64'd0;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_TRANS:
            begin
                mul_a = e1[2] ? v_reg : u_reg;
                mul_b = rd_bot_reg;
            end
            S_SQUARE:
            begin
                mul_a = 32'(x_val);
                mul_b = 32'(x_val);
            end
            S_NUMER:
            begin
                mul_a = 32'(rd_a_reg);
                mul_b = 32'(rd_b_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    sdr_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign div_n = num_reg[63] ? 64'(-num_reg) : 64'(num_reg);

    sdr_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .dividend  (div_n),
        .divisor   (den_reg),
        .done      (div_done),
        .saturated (div_sat),
        .quotient  (div_q)
    );

    always_comb
    begin
        if (num_reg[63])
        begin
            if (div_sat || div_q > 32'h8000_0000)
            begin
                coef_sat = 32'sh8000_0000;
            end
            else
            begin
                coef_sat = -$signed(div_q);
            end
        end
        else
        begin
            if (div_sat || div_q > 32'h7FFF_FFFF)
            begin
                coef_sat = 32'sh7FFF_FFFF;
            end
            else
            begin
                coef_sat = $signed(div_q);
            end
        end
    end

    // Matrix store, translated values and normalised values.
    always_ff @(posedge clk)
    begin
        if (accept && element_index < sdr_pkg::IDX_MATRIX_END)
        begin
            matrix_mem[element_index] <= element_value;
        end
        rd_top_reg <= matrix_mem[top_addr];
        rd_bot_reg <= matrix_mem[bot_addr];
        top_d_reg  <= rd_top_reg;

        if (state_reg == S_TRANS && cnt_reg >= 5'd2)
        begin
            t_mag_reg[e2] <= tmag;
            t_neg_reg[e2] <= tv[64];
        end

        if (state_reg == S_SQUARE && !cnt_reg[4])
        begin
            x_mem[e0] <= x_val;
        end
        rd_a_reg <= x_mem[a_addr];
        rd_b_reg <= x_mem[b_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cnt_reg          <= '0;
            k_reg            <= '0;
            div_wait_reg     <= 1'b0;
            div_start_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            div_start_reg    <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept && element_index == sdr_pkg::IDX_POINT_U)
                    begin
                        u_reg <= element_value;
                    end
                    if (accept && element_index == sdr_pkg::IDX_POINT_V)
                    begin
                        v_reg      <= element_value;
                        cnt_reg    <= '0;
                        allmag_reg <= '0;
                        state_reg  <= S_TRANS;
                    end
                end
                S_TRANS:
                begin
                    if (cnt_reg >= 5'd2)
                    begin
                        allmag_reg <= allmag_reg | tmag;
                    end
                    if (cnt_reg == 5'd17)
                    begin
                        sh_reg    <= allmag_reg | tmag;
                        shift_reg <= '0;
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_SHIFT:
                begin
                    // Smallest common shift that brings every magnitude below 2^29.
                    if (|sh_reg[63:29])
                    begin
                        sh_reg    <= sh_reg >> 1;
                        shift_reg <= shift_reg + 6'd1;
                    end
                    else
                    begin
                        cnt_reg   <= '0;
                        den_reg   <= '0;
                        state_reg <= S_SQUARE;
                    end
                end
                S_SQUARE:
                begin
                    if (cnt_reg != 5'd0)
                    begin
                        den_reg <= den_reg + prod;
                    end
                    if (cnt_reg == 5'd16)
                    begin
                        cnt_reg   <= '0;
                        k_reg     <= '0;
                        num_reg   <= '0;
                        state_reg <= S_NUMER;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_NUMER:
                begin
                    // Each product passes the operand and product registers.
                    if (cnt_reg >= 5'd2)
                    begin
                        num_reg <= cnt_reg[0] ? num_reg - prod : num_reg + prod;
                    end
                    if (cnt_reg == 5'd5)
                    begin
                        div_wait_reg <= 1'b0;
                        state_reg    <= S_DIVIDE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                S_DIVIDE:
                begin
                    if (is_degenerate || (div_wait_reg && div_done))
                    begin
                        result_valid_reg <= 1'b1;
                        coef_index_reg   <= k_reg;
                        coef_value_reg   <= is_degenerate ? 32'sd0 : coef_sat;
                        degenerate_reg   <= is_degenerate;
                        last_reg         <= k_reg == sdr_pkg::COEF_LAST;
                        if (k_reg == sdr_pkg::COEF_LAST)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + 3'd1;
                            cnt_reg   <= '0;
                            num_reg   <= '0;
                            state_reg <= S_NUMER;
                        end
                    end
                    else if (!div_wait_reg)
                    begin
                        div_start_reg <= 1'b1;
                        div_wait_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid      = result_valid_reg;
    assign coefficient_index = coef_index_reg;
    assign coefficient_value = coef_value_reg;
    assign degenerate        = degenerate_reg;
    assign last              = last_reg;

endmodule

### rtl/core/sdr_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_mul: shared signed multiplier
// One 32 by 32 signed multiply with a registered 64-bit product.
// ----------------------------------------------------------------------------
module sdr_mul
(
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] p
);

    logic signed [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

### rtl/core/sdr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdr_div: iterative ratio unit
// Restoring division giving floor(n * 2^30 / d) one quotient bit a cycle,
// with an overflow flag when the integer part is four or more.
// ----------------------------------------------------------------------------
module sdr_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic        saturated,
    output logic [31:0] quotient
);

    logic        run_reg;
    logic        done_reg;
    logic        sat_reg;
    logic [5:0]  step_reg;
    logic [65:0] rem_reg;
    logic [65:0] dvs_reg;
    logic [31:0] q_reg;

    logic [65:0] dvs_start;
    logic [65:0] rem_shift;
    logic        fits;

    // The divisor is scaled by four so that the remainder stays below it on every step.
    assign dvs_start = {divisor, 2'b00};
    assign rem_shift = {rem_reg[64:0], 1'b0};
    assign fits      = rem_shift >= dvs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= '0;
                if ({2'b00, dividend} >= dvs_start)
                begin
                    done_reg <= 1'b1;
                    run_reg  <= 1'b0;
                end
                else
                begin
                    run_reg <= 1'b1;
                end
            end
            else if (run_reg)
            begin
                if (step_reg == 6'd31)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sat_reg <= {2'b00, dividend} >= dvs_start;
            dvs_reg <= dvs_start;
            rem_reg <= {2'b00, dividend};
            q_reg   <= '0;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_shift - dvs_reg;
            end
            else
            begin
                rem_reg <= rem_shift;
            end
            q_reg <= {q_reg[30:0], fits};
        end
    end

    assign done      = done_reg;
    assign saturated = sat_reg;
    assign quotient  = q_reg;

endmodule
